/* design/bfac_pkg.sv */
// Shared types, codes and constants of the Bloom filter add/check engine.
`timescale 1ns / 1ps
`default_nettype none
package bfac_pkg;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] key_byte;
      logic       last_byte;
   } req_beat_type;

   typedef struct packed {
      logic       found;
      logic [1:0] done_kind;
   } rsp_beat_type;

   localparam logic [1:0] REQ_ADD   = 2'd0;
   localparam logic [1:0] REQ_CHECK = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_BITS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROBE_COUNT = 2'd1;

   localparam int FILTER_BITS_W = 21;
   localparam int PROBE_COUNT_W = 6;
   localparam logic [FILTER_BITS_W-1:0] FILTER_BITS_RESET = 21'd1048576;
   localparam logic [PROBE_COUNT_W-1:0] PROBE_COUNT_RESET = 6'd7;

   localparam int HASH_W = 64;
   localparam logic [HASH_W-1:0] FNV_START = 64'd2166136261;
   localparam int MOD_CNT_W = 6;
   localparam logic [MOD_CNT_W-1:0] MOD_LAST = 6'd63;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_LOAD,
      ST_READ,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic hash_en;
      logic key_end;
      logic hash_restart;
      logic mod_step;
      logic pos_load;
      logic probe_next;
      logic mem_rd;
      logic mem_wr;
      logic clr_start;
      logic clr_step;
   } dp_cmd_type;

   typedef struct packed {
      logic mod_done;
      logic clr_last;
      logic last_probe;
      logic bit_set;
   } dp_status_type;

endpackage
`default_nettype wire

/* design/bfac_datapath.sv */
// Datapath: key hashing, remainder unit, probe stepping, bit store and settings.
`timescale 1ns / 1ps
`default_nettype none
module bfac_datapath #(
   parameter int STORE_BITS = 1048576,
   parameter int MAX_PROBES = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire bfac_pkg::req_beat_type              req_beat,
   input  wire bfac_pkg::dp_cmd_type                cmd,
   output bfac_pkg::dp_status_type                  status,
   input  wire logic                                csr_write,
   input  wire logic [bfac_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [bfac_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int MW = $clog2(STORE_BITS + 1);
   localparam int STORE_BYTES = (STORE_BITS + 7) / 8;
   localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int PCW = $clog2(MAX_PROBES + 1);
   localparam int PIW = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
   localparam int HW = bfac_pkg::HASH_W;

   logic [bfac_pkg::FILTER_BITS_W-1:0] filter_bits_ff;
   logic [bfac_pkg::PROBE_COUNT_W-1:0] probe_count_ff;
   logic [HW-1:0] fnv_ff, fnv_in, poly_ff, poly_in, fnv_next, poly_next;
   logic [HW-1:0] sum_ff, sum_in, step_ff, step_in;
   logic [HW-1:0] div_ff [3];
   logic [HW-1:0] div_in [3];
   logic [MW-1:0] rem_ff [3];
   logic [MW-1:0] rem_in [3];
   logic [MW:0]   rem_t  [3];
   logic [bfac_pkg::MOD_CNT_W-1:0] mod_cnt_ff, mod_cnt_in;
   logic [MW-1:0] pos_ff, pos_in, h2m_ff, h2m_in, wrap_ff, wrap_in;
   logic [PIW-1:0] probe_ff, probe_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [7:0] rd_ff;
   logic [7:0] mem [STORE_BYTES];
   logic [MW-1:0] used_bits;
   logic [MW:0] mod_x, p1, p1r, p2;
   logic [PCW-1:0] used_probes;
   logic [HW:0] sum_full;
   logic [AW-1:0] addr;
   logic [7:0] mask;
   logic [HW-1:0] x;

   always_comb begin
      if (filter_bits_ff == '0) begin
         used_bits = MW'(1);
      end else if (32'(filter_bits_ff) > 32'(STORE_BITS)) begin
         used_bits = MW'(STORE_BITS);
      end else begin
         used_bits = MW'(filter_bits_ff);
      end
      if (probe_count_ff == '0) begin
         used_probes = PCW'(1);
      end else if (32'(probe_count_ff) > 32'(MAX_PROBES)) begin
         used_probes = PCW'(MAX_PROBES);
      end else begin
         used_probes = PCW'(probe_count_ff);
      end
   end

   assign mod_x = {1'b0, used_bits};

   always_comb begin
      x = fnv_ff ^ {56'd0, req_beat.key_byte};
      fnv_next = (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
      poly_next = (poly_ff << 5) - poly_ff + {56'd0, req_beat.key_byte};
      fnv_in = fnv_ff;
      poly_in = poly_ff;
      if (cmd.hash_restart || (cmd.hash_en && cmd.key_end)) begin
         fnv_in = bfac_pkg::FNV_START;
         poly_in = '0;
      end else if (cmd.hash_en) begin
         fnv_in = fnv_next;
         poly_in = poly_next;
      end
   end

   always_comb begin
      mod_cnt_in = mod_cnt_ff;
      for (int i = 0; i < 3; i++) begin
         rem_t[i] = {rem_ff[i], div_ff[i][HW-1]};
         div_in[i] = div_ff[i];
         rem_in[i] = rem_ff[i];
      end
      if (cmd.hash_en && cmd.key_end) begin
         div_in[0] = fnv_next;
         div_in[1] = poly_next;
         div_in[2] = '0 - HW'(used_bits);
         for (int i = 0; i < 3; i++) begin
            rem_in[i] = '0;
         end
         mod_cnt_in = '0;
      end else if (cmd.mod_step) begin
         for (int i = 0; i < 3; i++) begin
            div_in[i] = div_ff[i] << 1;
            rem_in[i] = (rem_t[i] >= mod_x) ? MW'(rem_t[i] - mod_x) : MW'(rem_t[i]);
         end
         mod_cnt_in = mod_cnt_ff + 1'b1;
      end
   end

   always_comb begin
      sum_full = {1'b0, sum_ff} + {1'b0, step_ff};
      p1 = {1'b0, pos_ff} + {1'b0, h2m_ff};
      p1r = (p1 >= mod_x) ? p1 - mod_x : p1;
      if (!sum_full[HW]) begin
         p2 = p1r;
      end else if (p1r >= {1'b0, wrap_ff}) begin
         p2 = p1r - {1'b0, wrap_ff};
      end else begin
         p2 = p1r + mod_x - {1'b0, wrap_ff};
      end
      sum_in = sum_ff;
      step_in = step_ff;
      pos_in = pos_ff;
      h2m_in = h2m_ff;
      wrap_in = wrap_ff;
      probe_in = probe_ff;
      if (cmd.hash_en && cmd.key_end) begin
         sum_in = fnv_next;
         step_in = poly_next;
      end
      if (cmd.pos_load) begin
         pos_in = rem_ff[0];
         h2m_in = rem_ff[1];
         wrap_in = rem_ff[2];
         probe_in = '0;
      end else if (cmd.probe_next) begin
         sum_in = sum_full[HW-1:0];
         pos_in = p2[MW-1:0];
         probe_in = probe_ff + 1'b1;
      end
      clr_cnt_in = clr_cnt_ff;
      if (cmd.clr_start) begin
         clr_cnt_in = '0;
      end else if (cmd.clr_step) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_bits_ff <= bfac_pkg::FILTER_BITS_RESET;
         probe_count_ff <= bfac_pkg::PROBE_COUNT_RESET;
         fnv_ff <= bfac_pkg::FNV_START;
         poly_ff <= '0;
         mod_cnt_ff <= '0;
         probe_ff <= '0;
         clr_cnt_ff <= '0;
      end else begin
         if (csr_write && csr_index == bfac_pkg::CSR_FILTER_BITS) begin
            filter_bits_ff <= csr_data[bfac_pkg::FILTER_BITS_W-1:0];
         end
         if (csr_write && csr_index == bfac_pkg::CSR_PROBE_COUNT) begin
            probe_count_ff <= csr_data[bfac_pkg::PROBE_COUNT_W-1:0];
         end
         fnv_ff <= fnv_in;
         poly_ff <= poly_in;
         mod_cnt_ff <= mod_cnt_in;
         probe_ff <= probe_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         div_ff[i] <= div_in[i];
         rem_ff[i] <= rem_in[i];
      end
      sum_ff <= sum_in;
      step_ff <= step_in;
      pos_ff <= pos_in;
      h2m_ff <= h2m_in;
      wrap_ff <= wrap_in;
   end

   assign addr = AW'(pos_ff >> 3);
   assign mask = 8'd1 << pos_ff[2:0];

   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         mem[clr_cnt_ff] <= '0;
      end else if (cmd.mem_wr) begin
         mem[addr] <= rd_ff | mask;
      end
      if (cmd.mem_rd) begin
         rd_ff <= mem[addr];
      end
   end

   assign status.mod_done = (mod_cnt_ff == bfac_pkg::MOD_LAST);
   assign status.clr_last = (clr_cnt_ff == AW'(STORE_BYTES - 1));
   assign status.last_probe = ((PCW'(probe_ff) + PCW'(1)) == used_probes);
   assign status.bit_set = rd_ff[pos_ff[2:0]];

endmodule
`default_nettype wire

/* design/bfac_control.sv */
// Controller: state machine that sequences hashing, reduction, probes and clearing.
`timescale 1ns / 1ps
`default_nettype none
module bfac_control (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire bfac_pkg::req_beat_type   req_beat,
   output logic                          busy,
   output bfac_pkg::dp_cmd_type          cmd,
   input  wire bfac_pkg::dp_status_type  status,
   output logic                          rsp_strobe,
   output bfac_pkg::rsp_beat_type        rsp_beat
);

   bfac_pkg::state_type state_ff, state_in;
   logic [1:0] kind_ff, kind_in;
   logic report_ff, report_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   bfac_pkg::rsp_beat_type rsp_beat_ff, rsp_beat_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfac_pkg::ST_CLEAR;
         report_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         report_ff <= report_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      rsp_beat_ff <= rsp_beat_in;
   end

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      report_in = report_ff;
      rsp_strobe_in = 1'b0;
      rsp_beat_in = rsp_beat_ff;
      cmd = '0;
      unique case (state_ff)
         bfac_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               if (report_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_beat_in.found = 1'b0;
                  rsp_beat_in.done_kind = bfac_pkg::REQ_CLEAR;
               end
               report_in = 1'b0;
               state_in = bfac_pkg::ST_IDLE;
            end
         end
         bfac_pkg::ST_IDLE: begin
            if (start) begin
               case (req_beat.req_type) inside
                  bfac_pkg::REQ_CLEAR: begin
                     cmd.hash_restart = 1'b1;
                     cmd.clr_start = 1'b1;
                     report_in = 1'b1;
                     state_in = bfac_pkg::ST_CLEAR;
                  end
                  bfac_pkg::REQ_ADD, bfac_pkg::REQ_CHECK: begin
                     cmd.hash_en = 1'b1;
                     if (req_beat.last_byte) begin
                        cmd.key_end = 1'b1;
                        kind_in = req_beat.req_type;
                        state_in = bfac_pkg::ST_MOD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         bfac_pkg::ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (status.mod_done) begin
               state_in = bfac_pkg::ST_LOAD;
            end
         end
         bfac_pkg::ST_LOAD: begin
            cmd.pos_load = 1'b1;
            state_in = bfac_pkg::ST_READ;
         end
         bfac_pkg::ST_READ: begin
            cmd.mem_rd = 1'b1;
            state_in = bfac_pkg::ST_UPDATE;
         end
         bfac_pkg::ST_UPDATE: begin
            cmd.mem_wr = (kind_ff == bfac_pkg::REQ_ADD);
            if (kind_ff == bfac_pkg::REQ_CHECK && !status.bit_set) begin
               rsp_strobe_in = 1'b1;
               rsp_beat_in.found = 1'b0;
               rsp_beat_in.done_kind = kind_ff;
               state_in = bfac_pkg::ST_IDLE;
            end else if (status.last_probe) begin
               rsp_strobe_in = 1'b1;
               rsp_beat_in.found = (kind_ff == bfac_pkg::REQ_CHECK);
               rsp_beat_in.done_kind = kind_ff;
               state_in = bfac_pkg::ST_IDLE;
            end else begin
               cmd.probe_next = 1'b1;
               state_in = bfac_pkg::ST_READ;
            end
         end
         default: begin
            state_in = bfac_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != bfac_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_beat = rsp_beat_ff;

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("two result beats in a row");

   a_clear_enters: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_beat.req_type == bfac_pkg::REQ_CLEAR)
      |=> state_ff == bfac_pkg::ST_CLEAR)
      else $error("clear request did not start clearing pass");

   a_add_not_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_beat_ff.done_kind != bfac_pkg::REQ_CHECK) |-> !rsp_beat_ff.found)
      else $error("found set on a non-check result");

   a_update_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == bfac_pkg::ST_UPDATE |-> $past(state_ff) == bfac_pkg::ST_READ)
      else $error("update without a preceding read");

endmodule
`default_nettype wire

/* design/bloom_filter_add_check_top.sv */
// Top level of the Bloom filter add/check engine.
// Key bytes arrive one beat at a time on the req_ channel: a beat is taken
// when start is high and busy is low. A non-final key byte leaves the engine
// idle, ready for the next byte. On the final byte of an add or check key,
// three 64-step remainder lanes reduce both hashes and the 2^64 wrap term by
// the filter size, then each probe passes through a read state and an update
// state (a write for an add) on the single-port bit store. The result beat
// follows the last probe; a check may end early at the first clear bit.
// A clear request sweeps the store one byte per cycle and then gives its
// result beat. Each result beat is on rsp_beat, marked by rsp_strobe for one
// cycle; the receiver cannot hold it off. Reset runs the same clearing sweep
// with no result beat, and busy stays high until it ends. The csr_ channel
// is always ready; settings are to be written by the user only while the
// engine is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module bloom_filter_add_check_top #(
   parameter int STORE_BITS = 1048576,
   parameter int MAX_PROBES = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire bfac_pkg::req_beat_type            req_beat,
   output logic                                   rsp_strobe,
   output bfac_pkg::rsp_beat_type                 rsp_beat,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [bfac_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [bfac_pkg::CSR_DATA_W-1:0]   csr_data
);

   bfac_pkg::dp_cmd_type cmd;
   bfac_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   bfac_control u_control (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_beat   (req_beat),
      .busy       (busy),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_beat   (rsp_beat)
   );

   bfac_datapath #(
      .STORE_BITS (STORE_BITS),
      .MAX_PROBES (MAX_PROBES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_beat  (req_beat),
      .cmd       (cmd),
      .status    (status),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule
`default_nettype wire
